// ===== hdl/par_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package par_pkg;

    localparam int ANG_Q_W  = 16;
    localparam int RAD_Q_W  = 17;
    localparam int ROM_DEPTH = 257;

    localparam logic [2:0] OCT_SWAP = 3'b001;
    localparam logic [2:0] OCT_YNEG = 3'b010;
    localparam logic [2:0] OCT_ZNEG = 3'b100;

    localparam logic [16:0] RADIUS_MAX = 17'd131071;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] third;
        logic signed [10:0] ang;
        logic [16:0]        rad;
    } t_side;

    typedef struct packed {
        logic [2:0]  oct;
        logic        eq;
        logic        zero;
        logic [15:0] mag_z;
        logic [15:0] mag_y;
        t_side       side;
    } t_actl;

    typedef struct packed {
        logic [15:0] mag_z;
        logic [15:0] mag_y;
        logic [14:0] c;
        logic        is0;
        logic        isc0;
        logic        sat;
        logic signed [10:0] ang;
        t_side       side;
    } t_rctl;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'(-v);
        return v[15] ? neg : 16'(v);
    endfunction

    localparam logic [7:0] ATAN_ROM [0:ROM_DEPTH-1] = '{
        8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h03, 8'h04, 8'h04, 8'h05, 8'h06, 8'h06, 8'h07,
        8'h08, 8'h08, 8'h09, 8'h0A, 8'h0A, 8'h0B, 8'h0B, 8'h0C, 8'h0D, 8'h0D, 8'h0E, 8'h0F,
        8'h0F, 8'h10, 8'h10, 8'h11, 8'h12, 8'h12, 8'h13, 8'h14, 8'h14, 8'h15, 8'h16, 8'h16,
        8'h17, 8'h17, 8'h18, 8'h19, 8'h19, 8'h1A, 8'h1B, 8'h1B, 8'h1C, 8'h1C, 8'h1D, 8'h1E,
        8'h1E, 8'h1F, 8'h1F, 8'h20, 8'h21, 8'h21, 8'h22, 8'h22, 8'h23, 8'h24, 8'h24, 8'h25,
        8'h26, 8'h26, 8'h27, 8'h27, 8'h28, 8'h29, 8'h29, 8'h2A, 8'h2A, 8'h2B, 8'h2C, 8'h2C,
        8'h2D, 8'h2D, 8'h2E, 8'h2E, 8'h2F, 8'h30, 8'h30, 8'h31, 8'h31, 8'h32, 8'h33, 8'h33,
        8'h34, 8'h34, 8'h35, 8'h35, 8'h36, 8'h37, 8'h37, 8'h38, 8'h38, 8'h39, 8'h39, 8'h3A,
        8'h3A, 8'h3B, 8'h3C, 8'h3C, 8'h3D, 8'h3D, 8'h3E, 8'h3E, 8'h3F, 8'h3F, 8'h40, 8'h41,
        8'h41, 8'h42, 8'h42, 8'h43, 8'h43, 8'h44, 8'h44, 8'h45, 8'h45, 8'h46, 8'h46, 8'h47,
        8'h47, 8'h48, 8'h48, 8'h49, 8'h4A, 8'h4A, 8'h4B, 8'h4B, 8'h4C, 8'h4C, 8'h4D, 8'h4D,
        8'h4E, 8'h4E, 8'h4F, 8'h4F, 8'h50, 8'h50, 8'h51, 8'h51, 8'h52, 8'h52, 8'h53, 8'h53,
        8'h54, 8'h54, 8'h54, 8'h55, 8'h55, 8'h56, 8'h56, 8'h57, 8'h57, 8'h58, 8'h58, 8'h59,
        8'h59, 8'h5A, 8'h5A, 8'h5B, 8'h5B, 8'h5B, 8'h5C, 8'h5C, 8'h5D, 8'h5D, 8'h5E, 8'h5E,
        8'h5F, 8'h5F, 8'h60, 8'h60, 8'h60, 8'h61, 8'h61, 8'h62, 8'h62, 8'h63, 8'h63, 8'h63,
        8'h64, 8'h64, 8'h65, 8'h65, 8'h66, 8'h66, 8'h66, 8'h67, 8'h67, 8'h68, 8'h68, 8'h68,
        8'h69, 8'h69, 8'h6A, 8'h6A, 8'h6A, 8'h6B, 8'h6B, 8'h6C, 8'h6C, 8'h6C, 8'h6D, 8'h6D,
        8'h6E, 8'h6E, 8'h6E, 8'h6F, 8'h6F, 8'h70, 8'h70, 8'h70, 8'h71, 8'h71, 8'h71, 8'h72,
        8'h72, 8'h73, 8'h73, 8'h73, 8'h74, 8'h74, 8'h74, 8'h75, 8'h75, 8'h76, 8'h76, 8'h76,
        8'h77, 8'h77, 8'h77, 8'h78, 8'h78, 8'h78, 8'h79, 8'h79, 8'h79, 8'h7A, 8'h7A, 8'h7A,
        8'h7B, 8'h7B, 8'h7B, 8'h7C, 8'h7C, 8'h7C, 8'h7D, 8'h7D, 8'h7D, 8'h7E, 8'h7E, 8'h7E,
        8'h7F, 8'h7F, 8'h7F, 8'h80, 8'h80
    };

    localparam logic [14:0] SINE_ROM [0:ROM_DEPTH-1] = '{
        15'd0, 15'd101, 15'd201, 15'd302, 15'd402, 15'd503, 15'd603, 15'd704, 15'd804,
        15'd904, 15'd1005, 15'd1105, 15'd1205, 15'd1306, 15'd1406, 15'd1506, 15'd1606,
        15'd1706, 15'd1806, 15'd1906, 15'd2006, 15'd2105, 15'd2205, 15'd2305, 15'd2404,
        15'd2503, 15'd2603, 15'd2702, 15'd2801, 15'd2900, 15'd2999, 15'd3098, 15'd3196,
        15'd3295, 15'd3393, 15'd3492, 15'd3590, 15'd3688, 15'd3786, 15'd3883, 15'd3981,
        15'd4078, 15'd4176, 15'd4273, 15'd4370, 15'd4467, 15'd4563, 15'd4660, 15'd4756,
        15'd4852, 15'd4948, 15'd5044, 15'd5139, 15'd5235, 15'd5330, 15'd5425, 15'd5520,
        15'd5614, 15'd5708, 15'd5803, 15'd5897, 15'd5990, 15'd6084, 15'd6177, 15'd6270,
        15'd6363, 15'd6455, 15'd6547, 15'd6639, 15'd6731, 15'd6823, 15'd6914, 15'd7005,
        15'd7096, 15'd7186, 15'd7276, 15'd7366, 15'd7456, 15'd7545, 15'd7635, 15'd7723,
        15'd7812, 15'd7900, 15'd7988, 15'd8076, 15'd8163, 15'd8250, 15'd8337, 15'd8423,
        15'd8509, 15'd8595, 15'd8680, 15'd8765, 15'd8850, 15'd8935, 15'd9019, 15'd9102,
        15'd9186, 15'd9269, 15'd9352, 15'd9434, 15'd9516, 15'd9598, 15'd9679, 15'd9760,
        15'd9841, 15'd9921, 15'd10001, 15'd10080, 15'd10159, 15'd10238, 15'd10316,
        15'd10394, 15'd10471, 15'd10549, 15'd10625, 15'd10702, 15'd10778, 15'd10853,
        15'd10928, 15'd11003, 15'd11077, 15'd11151, 15'd11224, 15'd11297, 15'd11370,
        15'd11442, 15'd11514, 15'd11585, 15'd11656, 15'd11727, 15'd11797, 15'd11866,
        15'd11935, 15'd12004, 15'd12072, 15'd12140, 15'd12207, 15'd12274, 15'd12340,
        15'd12406, 15'd12472, 15'd12537, 15'd12601, 15'd12665, 15'd12729, 15'd12792,
        15'd12854, 15'd12916, 15'd12978, 15'd13039, 15'd13100, 15'd13160, 15'd13219,
        15'd13279, 15'd13337, 15'd13395, 15'd13453, 15'd13510, 15'd13567, 15'd13623,
        15'd13678, 15'd13733, 15'd13788, 15'd13842, 15'd13896, 15'd13949, 15'd14001,
        15'd14053, 15'd14104, 15'd14155, 15'd14206, 15'd14256, 15'd14305, 15'd14354,
        15'd14402, 15'd14449, 15'd14497, 15'd14543, 15'd14589, 15'd14635, 15'd14680,
        15'd14724, 15'd14768, 15'd14811, 15'd14854, 15'd14896, 15'd14937, 15'd14978,
        15'd15019, 15'd15059, 15'd15098, 15'd15137, 15'd15175, 15'd15213, 15'd15250,
        15'd15286, 15'd15322, 15'd15357, 15'd15392, 15'd15426, 15'd15460, 15'd15493,
        15'd15525, 15'd15557, 15'd15588, 15'd15619, 15'd15649, 15'd15679, 15'd15707,
        15'd15736, 15'd15763, 15'd15791, 15'd15817, 15'd15843, 15'd15868, 15'd15893,
        15'd15917, 15'd15941, 15'd15964, 15'd15986, 15'd16008, 15'd16029, 15'd16049,
        15'd16069, 15'd16088, 15'd16107, 15'd16125, 15'd16143, 15'd16160, 15'd16176,
        15'd16192, 15'd16207, 15'd16221, 15'd16235, 15'd16248, 15'd16261, 15'd16273,
        15'd16284, 15'd16295, 15'd16305, 15'd16315, 15'd16324, 15'd16332, 15'd16340,
        15'd16347, 15'd16353, 15'd16359, 15'd16364, 15'd16369, 15'd16373, 15'd16376,
        15'd16379, 15'd16381, 15'd16383, 15'd16384, 15'd16384
    };

endpackage
`default_nettype wire

// ===== hdl/par_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface par_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] first_coord;
    logic signed [15:0] second_coord;
    logic signed [15:0] third_coord;
    modport source (output valid, mode, first_coord, second_coord, third_coord,
                    input ready);
    modport sink   (input valid, mode, first_coord, second_coord, third_coord,
                    output ready);
endinterface

interface par_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] polar_angle;
    logic [16:0]        radius;
    modport source (output valid, polar_angle, radius, input ready);
    modport sink   (input valid, polar_angle, radius, output ready);
endinterface
`default_nettype wire

// ===== hdl/par_pass.sv =====
`timescale 1ns / 1ps
`default_nettype none
module par_pass (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ce,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_z,
    input  wire logic signed [15:0] i_y,
    input  par_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic signed [10:0]      o_ang,
    output logic [16:0]             o_rad,
    output par_pkg::t_side          o_side
);
    import par_pkg::*;

    // angle divider: stage 0 is the decode, k holds k quotient bits
    logic          r_av     [0:ANG_Q_W];
    t_actl         r_actl   [0:ANG_Q_W];
    logic [15:0]   r_arem   [0:ANG_Q_W];
    logic [15:0]   r_alarge [0:ANG_Q_W];
    logic [15:0]   r_aq     [0:ANG_Q_W];
    logic [15:0]   n_arem   [0:ANG_Q_W-1];
    logic          n_abit   [0:ANG_Q_W-1];

    // angle stage
    logic               r_pv;
    logic signed [10:0] r_pang;
    logic [15:0]        r_pmz;
    logic [15:0]        r_pmy;
    t_side              r_pside;

    // radius divider
    logic          r_rv   [0:RAD_Q_W];
    t_rctl         r_rctl [0:RAD_Q_W];
    logic [14:0]   r_rrem [0:RAD_Q_W];
    logic [16:0]   r_rq   [0:RAD_Q_W];
    logic [14:0]   n_rrem [0:RAD_Q_W-1];
    logic          n_rbit [0:RAD_Q_W-1];

    logic               r_ov;
    logic signed [10:0] r_oang;
    logic [16:0]        r_orad;
    t_side              r_oside;

    // decode
    logic [15:0] n_mz, n_my;
    logic        n_swap;
    t_actl       n_actl0;
    always_comb begin
        n_mz   = mag16(i_z);
        n_my   = mag16(i_y);
        n_swap = n_mz > n_my;
        n_actl0.oct   = (i_z[15] ? OCT_ZNEG : 3'b000) | (i_y[15] ? OCT_YNEG : 3'b000)
                      | (n_swap ? OCT_SWAP : 3'b000);
        n_actl0.eq    = n_mz == n_my;
        n_actl0.zero  = (n_mz == 16'd0) && (n_my == 16'd0);
        n_actl0.mag_z = n_mz;
        n_actl0.mag_y = n_my;
        n_actl0.side  = i_side;
    end

    // one restoring step per stage
    always_comb begin
        logic [16:0] t;
        for (int k = 0; k < ANG_Q_W; k++) begin
            t = {r_arem[k], 1'b0};
            if (t >= {1'b0, r_alarge[k]}) begin
                n_arem[k] = 16'(t - {1'b0, r_alarge[k]});
                n_abit[k] = 1'b1;
            end else begin
                n_arem[k] = t[15:0];
                n_abit[k] = 1'b0;
            end
        end
    end

    // rounding, table lookup and octant unfold
    logic [16:0]        n_qr;
    logic [8:0]         n_idx;
    logic signed [10:0] n_r;
    logic signed [10:0] n_ang;
    always_comb begin
        n_qr  = {1'b0, r_aq[ANG_Q_W]} + (r_aq[ANG_Q_W][7] ? 17'd256 : 17'd0);
        n_idx = n_qr[16:8];
        n_r   = r_actl[ANG_Q_W].eq ? 11'sd128 : $signed({3'b000, ATAN_ROM[n_idx]});
        case (r_actl[ANG_Q_W].oct)
            3'b000:                          n_ang = n_r;
            OCT_SWAP:                        n_ang = 11'sd256 - n_r;
            OCT_YNEG:                        n_ang = 11'sd512 - n_r;
            OCT_YNEG | OCT_SWAP:             n_ang = n_r + 11'sd256;
            OCT_ZNEG:                        n_ang = -n_r;
            OCT_ZNEG | OCT_SWAP:             n_ang = n_r - 11'sd256;
            OCT_ZNEG | OCT_YNEG:             n_ang = n_r - 11'sd512;
            default:                         n_ang = -(n_r + 11'sd256);
        endcase
        if (r_actl[ANG_Q_W].zero) begin
            n_ang = 11'sd0;
        end
    end

    // fold to a quarter turn and look up the cosine
    logic [10:0] n_aabs;
    logic [8:0]  n_fold;
    t_rctl       n_rctl0;
    always_comb begin
        n_aabs = r_pang[10] ? 11'(-r_pang) : 11'(r_pang);
        n_fold = (n_aabs >= 11'd256) ? 9'(11'd512 - n_aabs) : n_aabs[8:0];
        n_rctl0.mag_z = r_pmz;
        n_rctl0.mag_y = r_pmy;
        n_rctl0.c     = SINE_ROM[9'(9'd256 - n_fold)];
        n_rctl0.is0   = n_fold == 9'd0;
        n_rctl0.isc0  = n_rctl0.c == 15'd0;
        n_rctl0.sat   = {2'b00, r_pmy} >= {n_rctl0.c, 3'b000};
        n_rctl0.ang   = r_pang;
        n_rctl0.side  = r_pside;
    end

    // dividend is mag_y shifted left by 14
    always_comb begin
        logic [16:0] dvd;
        logic [15:0] t;
        for (int j = 0; j < RAD_Q_W; j++) begin
            dvd = {r_rctl[j].mag_y[2:0], 14'd0};
            t   = {r_rrem[j], dvd[5'(RAD_Q_W - 1 - j)]};
            if (t >= {1'b0, r_rctl[j].c}) begin
                n_rrem[j] = 15'(t - {1'b0, r_rctl[j].c});
                n_rbit[j] = 1'b1;
            end else begin
                n_rrem[j] = t[14:0];
                n_rbit[j] = 1'b0;
            end
        end
    end

    logic [16:0] n_rad;
    always_comb begin
        if (r_rctl[RAD_Q_W].is0) begin
            n_rad = {1'b0, r_rctl[RAD_Q_W].mag_y};
        end else if (r_rctl[RAD_Q_W].isc0) begin
            n_rad = {1'b0, r_rctl[RAD_Q_W].mag_z};
        end else if (r_rctl[RAD_Q_W].sat) begin
            n_rad = RADIUS_MAX;
        end else begin
            n_rad = r_rq[RAD_Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ANG_Q_W; k++) r_av[k] <= 1'b0;
            for (int j = 0; j <= RAD_Q_W; j++) r_rv[j] <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_av[0] <= i_valid;
            for (int k = 1; k <= ANG_Q_W; k++) r_av[k] <= r_av[k-1];
            r_pv    <= r_av[ANG_Q_W];
            r_rv[0] <= r_pv;
            for (int j = 1; j <= RAD_Q_W; j++) r_rv[j] <= r_rv[j-1];
            r_ov    <= r_rv[RAD_Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_actl[0]   <= n_actl0;
            r_arem[0]   <= n_swap ? n_my : n_mz;
            r_alarge[0] <= n_swap ? n_mz : n_my;
            r_aq[0]     <= 16'd0;
            for (int k = 1; k <= ANG_Q_W; k++) begin
                r_actl[k]   <= r_actl[k-1];
                r_arem[k]   <= n_arem[k-1];
                r_alarge[k] <= r_alarge[k-1];
                r_aq[k]     <= {r_aq[k-1][14:0], n_abit[k-1]};
            end
            r_pang  <= n_ang;
            r_pmz   <= r_actl[ANG_Q_W].mag_z;
            r_pmy   <= r_actl[ANG_Q_W].mag_y;
            r_pside <= r_actl[ANG_Q_W].side;
            r_rctl[0] <= n_rctl0;
            r_rrem[0] <= {2'b00, r_pmy[15:3]};
            r_rq[0]   <= 17'd0;
            for (int j = 1; j <= RAD_Q_W; j++) begin
                r_rctl[j] <= r_rctl[j-1];
                r_rrem[j] <= n_rrem[j-1];
                r_rq[j]   <= {r_rq[j-1][15:0], n_rbit[j-1]};
            end
            r_oang  <= r_rctl[RAD_Q_W].ang;
            r_orad  <= n_rad;
            r_oside <= r_rctl[RAD_Q_W].side;
        end
    end

    assign o_valid = r_ov;
    assign o_ang   = r_oang;
    assign o_rad   = r_orad;
    assign o_side  = r_oside;
endmodule
`default_nettype wire

// ===== hdl/polar_angle_and_radius_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipeline: two 37-register passes, 74 registers between input accept and result valid
// throughput: one item per cycle while the sink is ready; one restoring divider bit per stage sets the depth
// flow control: the whole pipeline holds while a result waits and the sink is not ready
// reset: synchronous active low on i_rst_n, clears all valid bits; data is not reset
module polar_angle_and_radius_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    par_in_if.sink    i_vec,
    par_out_if.source o_res
);
    import par_pkg::*;

    // global pipeline advance: the output register is free or being drained
    logic ce;

    // first pass: angle and radius of (z, second coord)
    logic               p1_valid;
    logic signed [10:0] p1_ang;
    logic [16:0]        p1_rad;
    t_side              p1_side;
    t_side              p1_side_in;

    // second pass: (low half of first radius, third coord), used in 3d mode
    logic               p2_valid;
    logic signed [10:0] p2_ang;
    logic [16:0]        p2_rad;
    t_side              p2_side;
    t_side              p2_side_in;

    assign ce          = !p2_valid || o_res.ready;
    assign i_vec.ready = ce;

    // mode and y travel with the item; 2d results ride through the second pass
    always_comb begin
        p1_side_in.mode  = i_vec.mode;
        p1_side_in.third = i_vec.third_coord;
        p1_side_in.ang   = 11'sd0;
        p1_side_in.rad   = 17'd0;
    end

    par_pass u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_vec.valid),
        .i_z     (i_vec.first_coord),
        .i_y     (i_vec.second_coord),
        .i_side  (p1_side_in),
        .o_valid (p1_valid),
        .o_ang   (p1_ang),
        .o_rad   (p1_rad),
        .o_side  (p1_side)
    );

    always_comb begin
        p2_side_in      = p1_side;
        p2_side_in.ang  = p1_ang;
        p2_side_in.rad  = p1_rad;
    end

    // the first radius is cut to 16 bits and read back as signed
    par_pass u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (p1_valid),
        .i_z     ($signed(p1_rad[15:0])),
        .i_y     (p1_side.third),
        .i_side  (p2_side_in),
        .o_valid (p2_valid),
        .o_ang   (p2_ang),
        .o_rad   (p2_rad),
        .o_side  (p2_side)
    );

    // pick the pass that matches the item's mode
    assign o_res.valid       = p2_valid;
    assign o_res.polar_angle = p2_side.mode ? p2_ang : p2_side.ang;
    assign o_res.radius      = p2_side.mode ? p2_rad : p2_side.rad;
endmodule
`default_nettype wire

// ===== hdl/par_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module par_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [10:0] i_angle,
    input wire logic [16:0]        i_radius
);
    // result held while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_angle) && $stable(i_radius))
        else $error("result dropped or changed under stall");

    // angle stays within half a turn either way
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle <= 11'sd512) && (i_angle >= -11'sd512))
        else $error("angle out of range");

    // a zero radius must come with a zero angle
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_radius == 17'd0) |-> (i_angle == 11'sd0))
        else $error("zero radius with nonzero angle");

    // an empty output always leaves the input open
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind polar_angle_and_radius_core par_checker u_par_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_angle     (o_res.polar_angle),
    .i_radius    (o_res.radius)
);
`default_nettype wire

// ===== tb/sv/tb_polar_angle_and_radius_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_polar_angle_and_radius_core;
    import par_pkg::*;

    // pipeline is 74 deep, so the tail wait covers that with margin
    localparam int PIPE_DEPTH  = 74;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM    = 930;
    localparam logic MODE_2D = 1'b0;
    localparam logic MODE_3D = 1'b1;

    typedef struct {
        logic               mode;
        logic signed [15:0] z;
        logic signed [15:0] s;
        logic signed [15:0] y;
        logic               known;
        logic signed [10:0] ang;
        logic [16:0]        rad;
    } t_row;

    typedef struct {
        logic signed [10:0] ang;
        logic [16:0]        rad;
    } t_polar;

    logic i_clk;
    logic i_rst_n;

    par_in_if  vec_if ();
    par_out_if res_if ();

    polar_angle_and_radius_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_if.sink),
        .o_res   (res_if.source)
    );

    t_polar expected_q[$];
    int     n_errors;
    int     n_checked;
    int     n_sat;
    int     n_3d;
    int     idle_cycles;
    int     src_idle_pct;
    int     snk_idle_pct;
    bit     hold_off;
    bit     in_accept;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // fold the pair into an octant, round the ratio and unfold the table angle
    function automatic logic signed [11:0] pair_angle(input logic signed [16:0] z,
                                                      input logic signed [16:0] y);
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] t;
        logic [2:0]  oct;
        logic [33:0] q;
        logic [33:0] idx;
        logic signed [11:0] r;
        a   = z < 0 ? 17'(-z) : 17'(z);
        b   = y < 0 ? 17'(-y) : 17'(y);
        oct = 3'b000;
        if (z < 0) oct = oct | OCT_ZNEG;
        if (y < 0) oct = oct | OCT_YNEG;
        if (a == b) begin
            if (a == 0) return 12'sd0;
            r = 12'sd128;
        end else begin
            if (a > b) begin
                t = a; a = b; b = t;
                oct = oct | OCT_SWAP;
            end
            q = ({17'd0, a} << 16) / b;
            if (q[7:0] >= 8'h80) q = q + 34'h100;
            idx = q >> 8;
            if (idx > 256) idx = 256;
            r = 12'(ATAN_ROM[idx[8:0]]);
        end
        case (oct)
            3'd0:    return r;
            3'd1:    return 12'sd256 - r;
            3'd2:    return 12'sd512 - r;
            3'd3:    return r + 12'sd256;
            3'd4:    return -r;
            3'd5:    return r - 12'sd256;
            3'd6:    return r - 12'sd512;
            default: return -(r + 12'sd256);
        endcase
    endfunction

    // radius as |y| over the cosine of the folded angle, saturated
    function automatic logic [16:0] pair_radius(input logic signed [16:0] z,
                                                input logic signed [16:0] y,
                                                output logic signed [11:0] ang);
        logic signed [11:0] f;
        logic [16:0] my;
        logic [31:0] c;
        logic [31:0] r;
        ang = pair_angle(z, y);
        f   = ang < 0 ? -ang : ang;
        if (f >= 256) f = 12'sd512 - f;
        my = y < 0 ? 17'(-y) : 17'(y);
        if (f == 0) return my;
        c = 32'(SINE_ROM[9'(256 - f)]);
        if (c == 0) return z < 0 ? 17'(-z) : 17'(z);
        r = ({15'd0, my} * 32'd16384) / c;
        return r > RADIUS_MAX ? RADIUS_MAX : r[16:0];
    endfunction

    function automatic t_polar polar_of(input logic mode, input logic signed [15:0] z,
                                        input logic signed [15:0] s,
                                        input logic signed [15:0] y);
        t_polar res;
        logic signed [11:0] a0;
        logic signed [11:0] a1;
        logic [16:0] r0;
        if (mode == MODE_3D) begin
            r0 = pair_radius(17'(z), 17'(s), a0);
            // the first radius is reused as a signed 16-bit coordinate
            res.rad = pair_radius(17'($signed(r0[15:0])), 17'(y), a1);
        end else begin
            res.rad = pair_radius(17'(z), 17'(s), a1);
        end
        res.ang = a1[10:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_vec(input logic mode, input logic signed [15:0] z,
                            input logic signed [15:0] s, input logic signed [15:0] y);
        while ($urandom_range(99) < src_idle_pct) begin
            vec_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        vec_if.valid        <= 1'b1;
        vec_if.mode         <= mode;
        vec_if.first_coord  <= z;
        vec_if.second_coord <= s;
        vec_if.third_coord  <= y;
        do begin
            @(negedge i_clk);
        end while (!in_accept);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0:       return 16'(int'($urandom_range(16)) - 8);
            1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2:       return 16'(int'($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    // sample handshakes at the rising edge
    always @(posedge i_clk) begin
        in_accept <= i_rst_n && vec_if.valid && vec_if.ready;
        if (i_rst_n) begin
            if (vec_if.valid && vec_if.ready) begin
                expected_q.push_back(polar_of(vec_if.mode, vec_if.first_coord,
                                              vec_if.second_coord, vec_if.third_coord));
                if (vec_if.mode == MODE_3D) n_3d++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    if (res_if.polar_angle !== expected_q[0].ang)
                        report_mismatch("polar_angle", res_if.polar_angle, expected_q[0].ang);
                    if (res_if.radius !== expected_q[0].rad)
                        report_mismatch("radius", res_if.radius, expected_q[0].rad);
                    if (expected_q[0].rad == RADIUS_MAX) n_sat++;
                    void'(expected_q.pop_front());
                    n_checked++;
                end
            end
            if ((vec_if.valid && vec_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver ready, randomized at the falling edge
    always @(negedge i_clk) begin
        if (hold_off)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_row   row;
        t_polar want;
        int     tail;
        // directed rows; expected values only where they are obvious
        rows = '{
            '{MODE_2D, 16'sd0, 16'sd0, 16'sd0, 1'b1, 11'sd0, 17'd0},
            '{MODE_2D, 16'sd0, 16'sd100, 16'sd0, 1'b1, 11'sd0, 17'd100},
            '{MODE_2D, 16'sd0, -16'sd32768, 16'sd0, 1'b1, 11'sd512, 17'd32768},
            '{MODE_2D, 16'sd5, 16'sd0, 16'sd0, 1'b1, 11'sd256, 17'd5},
            '{MODE_2D, -16'sd32768, 16'sd0, 16'sd0, 1'b1, -11'sd256, 17'd32768},
            '{MODE_2D, 16'sd1000, 16'sd1000, 16'sd0, 1'b1, 11'sd128, 17'd0},
            '{MODE_2D, -16'sd32768, -16'sd32768, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, 16'sd32767, -16'sd32768, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, 16'sd32767, 16'sd1, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, -16'sd1, 16'sd32767, -16'sd1, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, -16'sd300, -16'sd7, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, 16'sd7, -16'sd300, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, 16'sd0, 16'sd0, 16'sd0, 1'b1, 11'sd0, 17'd0},
            '{MODE_3D, 16'sd3, 16'sd4, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, 16'sd20000, -16'sd25000, 16'sd1, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, 16'sd1, 16'sd32767, 16'sd0, 1'b0, 11'sd0, 17'd0},
            '{MODE_3D, -16'sd5461, 16'sd10922, -16'sd21845, 1'b0, 11'sd0, 17'd0},
            '{MODE_2D, 16'sd21845, -16'sd10923, 16'sh5555, 1'b0, 11'sd0, 17'd0}
        };
        n_errors = 0; n_checked = 0; n_sat = 0; n_3d = 0; idle_cycles = 0;
        src_idle_pct = 35; snk_idle_pct = 70; hold_off = 1'b0;
        vec_if.valid = 1'b0; vec_if.mode = MODE_2D;
        vec_if.first_coord = '0; vec_if.second_coord = '0; vec_if.third_coord = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            if (row.known) begin
                want = polar_of(row.mode, row.z, row.s, row.y);
                if (want.ang !== row.ang) report_mismatch("table angle", want.ang, row.ang);
                if (row.rad != 0 || row.z == 0)
                    if (want.rad !== row.rad)
                        report_mismatch("table radius", want.rad, row.rad);
            end
            send_vec(row.mode, row.z, row.s, row.y);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                src_idle_pct = 70; snk_idle_pct = 35;
            end
            if (n == 2 * N_RANDOM / 3) begin
                src_idle_pct = 0; snk_idle_pct = 0;
                // long receiver hold-off so the pipe fills and stalls its input
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_vec(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
        end
        vec_if.valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        tail = 0;
        while (tail < 4 * PIPE_DEPTH) begin
            @(posedge i_clk);
            tail++;
        end
        $display("checked %0d results, %0d from 3d vectors, %0d saturated radii",
                 n_checked, n_3d, n_sat);
        $display("idle mixes: sender-heavy, receiver-heavy, none, plus one long stall");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/par_pkg.sv
hdl/par_if.sv
hdl/par_pass.sv
hdl/polar_angle_and_radius_core.sv
hdl/par_checker.sv
tb/sv/tb_polar_angle_and_radius_core.sv
